### rtl/psds_pkg.sv
// shared types and constants for the priority sort dvfs scheduler
`timescale 1ns / 1ps
package psds_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int PCT_SCALE     = 100;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_FREQ = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_FREQ  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PW   = 3'd4;

   localparam logic [6:0]  THRESHOLD_RST = 7'd70;
   localparam logic [11:0] HIGH_FREQ_RST = 12'd2000;
   localparam logic [11:0] LOW_FREQ_RST  = 12'd1000;
   localparam logic [15:0] ACTIVE_PW_RST = 16'd1200;
   localparam logic [15:0] IDLE_PW_RST   = 16'd300;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] exec_time_ms;
      logic [7:0]  priority_req;
      logic        last_task;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_task_id;
      logic [7:0]  out_priority;
      logic [15:0] out_exec_time_ms;
      logic [6:0]  load_pct;
      logic        high_freq_sel;
      logic [11:0] freq_mhz;
      logic [15:0] power_mw;
      logic        is_idle_record;
      logic        overflow;
      logic        last_result;
   } rsp_word_type;

   // one sorted task or the idle marker, passed from front to back
   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  priority_val;
      logic [15:0] exec_time_ms;
      logic        idle;
      logic        ovf;
   } tok_type;

   typedef struct packed {
      logic [6:0]  threshold;
      logic [11:0] high_freq;
      logic [11:0] low_freq;
      logic [15:0] active_pw;
      logic [15:0] idle_pw;
   } cfg_type;

endpackage

### rtl/psds_front.sv
// front end: loads a batch into an insertion-sorted row of cells, then drains it
`timescale 1ns / 1ps
module psds_front
   import psds_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int TW    = 19
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_word_type  req_word,
   output logic          req_stall,
   output logic          q_push,
   output tok_type       q_tok,
   output logic [TW-1:0] q_total,
   input  logic          q_full
);

   localparam int CW = $clog2(SLOTS + 1);

   logic          drain_ff, drain_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] left_ff, left_in;
   logic [TW-1:0] total_ff, total_in;
   logic          drop_ff, drop_in;
   logic [7:0]    id_ff  [SLOTS];
   logic [7:0]    id_in  [SLOTS];
   logic [7:0]    pri_ff [SLOTS];
   logic [7:0]    pri_in [SLOTS];
   logic [15:0]   tim_ff [SLOTS];
   logic [15:0]   tim_in [SLOTS];
   logic [SLOTS-1:0] le;
   logic          acc;
   logic          room;

   assign req_stall = drain_ff;
   assign acc       = req_valid & ~drain_ff;
   assign room      = cnt_ff < CW'(SLOTS);

   // sorted cells: le is a prefix of ones, new word goes after the last one (stable)
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         le[j] = (CW'(j) < cnt_ff) && (pri_ff[j] <= req_word.priority_req);
      end
   end

   assign q_total = total_ff;

   always_comb begin
      q_tok.task_id      = id_ff[0];
      q_tok.priority_val = pri_ff[0];
      q_tok.exec_time_ms = tim_ff[0];
      q_tok.idle         = 1'b0;
      q_tok.ovf          = drop_ff;
      if (left_ff == '0) begin
         q_tok.task_id      = '0;
         q_tok.priority_val = '0;
         q_tok.exec_time_ms = '0;
         q_tok.idle         = 1'b1;
      end
   end

   always_comb begin
      drain_in = drain_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      total_in = total_ff;
      drop_in  = drop_ff;
      q_push   = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         id_in[j]  = id_ff[j];
         pri_in[j] = pri_ff[j];
         tim_in[j] = tim_ff[j];
      end
      if (acc) begin
         if (room) begin
            for (int j = 0; j < SLOTS; j++) begin
               if (!le[j]) begin
                  if (j == 0 || le[(j == 0) ? 0 : j-1]) begin
                     id_in[j]  = req_word.task_id;
                     pri_in[j] = req_word.priority_req;
                     tim_in[j] = req_word.exec_time_ms;
                  end else begin
                     id_in[j]  = id_ff[(j == 0) ? 0 : j-1];
                     pri_in[j] = pri_ff[(j == 0) ? 0 : j-1];
                     tim_in[j] = tim_ff[(j == 0) ? 0 : j-1];
                  end
               end
            end
            cnt_in   = cnt_ff + CW'(1);
            total_in = total_ff + TW'(req_word.exec_time_ms);
         end else begin
            drop_in = 1'b1;
         end
         if (req_word.last_task) begin
            drain_in = 1'b1;
            left_in  = cnt_in;
         end
      end else if (drain_ff && !q_full) begin
         q_push = 1'b1;
         if (left_ff != '0) begin
            // shift the row toward the head
            for (int j = 0; j < SLOTS - 1; j++) begin
               id_in[j]  = id_ff[j+1];
               pri_in[j] = pri_ff[j+1];
               tim_in[j] = tim_ff[j+1];
            end
            left_in = left_ff - CW'(1);
         end else begin
            drain_in = 1'b0;
            cnt_in   = '0;
            total_in = '0;
            drop_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         cnt_ff   <= '0;
         left_ff  <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         drain_ff <= drain_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         total_ff <= total_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < SLOTS; j++) begin
         id_ff[j]  <= id_in[j];
         pri_ff[j] <= pri_in[j];
         tim_ff[j] <= tim_in[j];
      end
   end

endmodule

### rtl/psds_queue.sv
// short fifo between the front and back ends
`timescale 1ns / 1ps
module psds_queue
   import psds_pkg::*;
#(
   parameter int DW = 60
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] wdata,
   output logic          full,
   input  logic          pop,
   output logic [DW-1:0] rdata,
   output logic          empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign full  = cnt_ff == (AW+1)'(DEPTH);
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + AW'(1);
         if (pop)  rp_ff <= rp_ff + AW'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + (AW+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

endmodule

### rtl/psds_back.sv
// back end: load share and power by iterative division, result register
`timescale 1ns / 1ps
module psds_back
   import psds_pkg::*;
#(
   parameter int TW = 19
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_empty,
   input  tok_type       q_tok,
   input  logic [TW-1:0] q_total,
   output logic          q_pop,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word,
   input  logic          rsp_stall
);

   localparam int RW = TW + 7;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PCT  = 3'd1;
   localparam logic [2:0] S_SEL  = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_PWR  = 3'd4;

   logic [2:0]    st_ff, st_in;
   logic [3:0]    step_ff, step_in;
   tok_type       tok_ff, tok_in;
   logic [TW-1:0] tot_ff, tot_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [6:0]    pct_ff, pct_in;
   logic          hsel_ff, hsel_in;
   logic [11:0]   freq_ff, freq_in;
   logic [27:0]   prem_ff, prem_in;
   logic [15:0]   pw_ff, pw_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;
   logic [RW-1:0] pdiv;
   logic [27:0]   wdiv;
   logic          emit;

   assign pdiv = RW'(tot_ff) << step_ff[2:0];
   assign wdiv = 28'(cfg.high_freq) << step_ff;

   assign q_pop     = (st_ff == S_IDLE) && !q_empty && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      st_in   = st_ff;
      step_in = step_ff;
      tok_in  = tok_ff;
      tot_in  = tot_ff;
      rem_in  = rem_ff;
      pct_in  = pct_ff;
      hsel_in = hsel_ff;
      freq_in = freq_ff;
      prem_in = prem_ff;
      pw_in   = pw_ff;
      emit    = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (q_pop) begin
               tok_in = q_tok;
               tot_in = q_total;
               rem_in = RW'(q_tok.exec_time_ms) * RW'(PCT_SCALE);
               pct_in = '0;
               step_in = 4'd6;
               if (!q_tok.idle) st_in = S_PCT;
            end
         end
         S_PCT: begin
            if (rem_ff >= pdiv) begin
               rem_in = rem_ff - pdiv;
               pct_in[step_ff[2:0]] = 1'b1;
            end
            if (step_ff == '0) st_in = S_SEL;
            else step_in = step_ff - 4'd1;
         end
         S_SEL: begin
            // a zero total gives a zero share
            if (tot_ff == '0) pct_in = '0;
            hsel_in = pct_in > cfg.threshold;
            freq_in = hsel_in ? cfg.high_freq : cfg.low_freq;
            prem_in = 28'(cfg.active_pw) * 28'(freq_in);
            st_in   = S_CHK;
         end
         S_CHK: begin
            pw_in   = '0;
            step_in = 4'd15;
            if (cfg.high_freq == '0 || prem_ff >= {cfg.high_freq, 16'd0}) begin
               pw_in = '1;
               emit  = 1'b1;
               st_in = S_IDLE;
            end else begin
               st_in = S_PWR;
            end
         end
         S_PWR: begin
            if (prem_ff >= wdiv) begin
               prem_in = prem_ff - wdiv;
               pw_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               emit  = 1'b1;
               st_in = S_IDLE;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (q_pop && q_tok.idle) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '0;
         rsp_word_in.freq_mhz       = cfg.low_freq;
         rsp_word_in.power_mw       = cfg.idle_pw;
         rsp_word_in.is_idle_record = 1'b1;
         rsp_word_in.overflow       = q_tok.ovf;
         rsp_word_in.last_result    = 1'b1;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.out_task_id      = tok_ff.task_id;
         rsp_word_in.out_priority     = tok_ff.priority_val;
         rsp_word_in.out_exec_time_ms = tok_ff.exec_time_ms;
         rsp_word_in.load_pct         = pct_ff;
         rsp_word_in.high_freq_sel    = hsel_ff;
         rsp_word_in.freq_mhz         = freq_ff;
         rsp_word_in.power_mw         = pw_in;
         rsp_word_in.is_idle_record   = 1'b0;
         rsp_word_in.overflow         = tok_ff.ovf;
         rsp_word_in.last_result      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      tok_ff      <= tok_in;
      tot_ff      <= tot_in;
      rem_ff      <= rem_in;
      pct_ff      <= pct_in;
      hsel_ff     <= hsel_in;
      freq_ff     <= freq_in;
      prem_ff     <= prem_in;
      pw_ff       <= pw_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

### rtl/priority_sort_dvfs_scheduler.sv
// top level of the priority sort dvfs scheduler
//
// usage:
// req channel takes one task word per cycle while req_stall is low. words of a
// batch are kept sorted by priority (ties in arrival order) as they arrive.
// the word with last_task set closes the batch: req_stall then stays high while
// the sorted tasks and one idle record move into a four-entry queue, one a
// cycle while it has room. words beyond the slot count are dropped and flagged
// in overflow. rsp channel gives one word per task, then the idle record with
// last_result. in the back end a task word goes through the pop, 7 steps of
// the share divider, a select and multiply step, a range check, 16 steps of
// the power divider and the handoff out of the result register. when the power
// saturates the power divider is skipped. the idle record goes from the pop
// straight to the result register. the next word leaves the queue only once
// the result register is empty, so a stalled receiver stops the back end; the
// front end drains into it until full and loads a new batch once drained.
// reset (synchronous, active high) empties the batch, the queue and the result
// register and loads the default register values.
// csr_we writes csr_wdata into the register selected by csr_index; unknown
// indexes are ignored. write only while the block is idle.
`timescale 1ns / 1ps
module priority_sort_dvfs_scheduler
   import psds_pkg::*;
#(
   parameter int TASK_SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_word_type          req_word,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word,
   input  logic                  rsp_stall,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW = $clog2(TASK_SLOTS * 65535 + 1);
   localparam int DW = $bits(tok_type) + TW;

   cfg_type       cfg_ff;
   logic          q_push, q_full, q_pop, q_empty;
   tok_type       f_tok, b_tok;
   logic [TW-1:0] f_total, b_total;
   logic [DW-1:0] q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.high_freq <= HIGH_FREQ_RST;
         cfg_ff.low_freq  <= LOW_FREQ_RST;
         cfg_ff.active_pw <= ACTIVE_PW_RST;
         cfg_ff.idle_pw   <= IDLE_PW_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.threshold <= csr_wdata[6:0];
            CSR_HIGH_FREQ: cfg_ff.high_freq <= csr_wdata[11:0];
            CSR_LOW_FREQ:  cfg_ff.low_freq  <= csr_wdata[11:0];
            CSR_ACTIVE_PW: cfg_ff.active_pw <= csr_wdata;
            CSR_IDLE_PW:   cfg_ff.idle_pw   <= csr_wdata;
            default: ;
         endcase
      end
   end

   psds_front #(.SLOTS(TASK_SLOTS), .TW(TW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .q_push    (q_push),
      .q_tok     (f_tok),
      .q_total   (f_total),
      .q_full    (q_full)
   );

   psds_queue #(.DW(DW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata ({f_tok, f_total}),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign b_tok   = q_rdata[DW-1:TW];
   assign b_total = q_rdata[TW-1:0];

   psds_back #(.TW(TW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_tok     (b_tok),
      .q_total   (b_total),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("queue overrun");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underrun");
   a_last_is_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last_result) |-> rsp_word.is_idle_record)
      else $error("last word is not the idle record");
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.load_pct <= 7'd100))
      else $error("load share out of range");
`endif

endmodule

### tb/tb_top.sv
// priority sort dvfs scheduler tb: directed and random batches checked against a predictor
`timescale 1ns / 1ps
module tb_top;
   import psds_pkg::*;

   localparam int SLOTS      = 8;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_WAIT = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   req_word_type          req_word = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  rsp_stall = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   priority_sort_dvfs_scheduler #(.TASK_SLOTS(SLOTS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_word(req_word), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .rsp_stall(rsp_stall),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor state
   cfg_type      sched_cfg;
   req_word_type batch_slots[SLOTS];
   int           batch_count;
   int unsigned  batch_total;
   bit           batch_dropped;

   req_word_type task_queue[$];
   rsp_word_type sched_expected[$];
   int           error_count = 0;
   int           words_seen = 0;
   int           batches_sent = 0;
   int           idle_cycles = 0;
   bit           quiet_phase = 1'b0;
   bit           hold_rsp = 1'b0;
   bit           stim_done = 1'b0;
   bit           req_taken = 1'b0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void predict_task(input req_word_type w);
      int          order[SLOTS];
      int          n, k, i;
      int unsigned pct, freq;
      longint unsigned pw;
      bit          hsel;
      rsp_word_type r;
      if (batch_count < SLOTS) begin
         batch_slots[batch_count] = w;
         batch_total += w.exec_time_ms;
         batch_count++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (!w.last_task) return;
      n = batch_count;
      for (i = 0; i < n; i++) begin
         k = i;
         while (k > 0 && batch_slots[order[k-1]].priority_req > batch_slots[i].priority_req) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = i;
      end
      for (i = 0; i < n; i++) begin
         pct = (batch_total == 0) ? 0
               : (batch_slots[order[i]].exec_time_ms * 100) / batch_total;
         hsel = pct > sched_cfg.threshold;
         freq = hsel ? sched_cfg.high_freq : sched_cfg.low_freq;
         if (sched_cfg.high_freq == 0) pw = 16'hFFFF;
         else begin
            pw = (longint'(sched_cfg.active_pw) * freq) / sched_cfg.high_freq;
            if (pw > 16'hFFFF) pw = 16'hFFFF;
         end
         r = '0;
         r.out_task_id = batch_slots[order[i]].task_id;
         r.out_priority = batch_slots[order[i]].priority_req;
         r.out_exec_time_ms = batch_slots[order[i]].exec_time_ms;
         r.load_pct = pct[6:0];
         r.high_freq_sel = hsel;
         r.freq_mhz = freq[11:0];
         r.power_mw = pw[15:0];
         r.overflow = batch_dropped;
         sched_expected.push_back(r);
      end
      r = '0;
      r.freq_mhz = sched_cfg.low_freq;
      r.power_mw = sched_cfg.idle_pw;
      r.is_idle_record = 1'b1;
      r.overflow = batch_dropped;
      r.last_result = 1'b1;
      sched_expected.push_back(r);
      batch_count = 0;
      batch_total = 0;
      batch_dropped = 1'b0;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         // a word stays put until the edge that accepts it
         if (!req_valid || req_taken) begin
            if (task_queue.size() > 0 && (quiet_phase || $urandom_range(99) >= 18)) begin
               req_word <= task_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= hold_rsp || (!quiet_phase && $urandom_range(99) < 18);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) predict_task(req_word);
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (sched_expected.size() == 0) report_mismatch("unexpected result word");
            else if (rsp_word !== sched_expected[0]) begin
               report_mismatch($sformatf("got %h expected %h", rsp_word, sched_expected[0]));
               void'(sched_expected.pop_front());
            end else void'(sched_expected.pop_front());
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
            idle_cycles <= 0;
         else if (task_queue.size() > 0 || sched_expected.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
               $display("timeout, %0d words outstanding", sched_expected.size());
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   task automatic add_task(input logic [7:0] id, input logic [15:0] tm,
                           input logic [7:0] pri, input logic last);
      req_word_type w;
      w.task_id = id; w.exec_time_ms = tm; w.priority_req = pri; w.last_task = last;
      task_queue.push_back(w);
      if (last) batches_sent++;
   endtask

   task automatic add_batch(input int len);
      logic [15:0] tm;
      logic [7:0]  pri;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(3))
            0: tm = 16'($urandom_range(3));
            1: tm = 16'hFFFF - 16'($urandom_range(3));
            default: tm = 16'($urandom);
         endcase
         pri = ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom);
         add_task(8'($urandom), tm, pri, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      while (task_queue.size() > 0 || req_valid || sched_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THRESHOLD: sched_cfg.threshold = val[6:0];
         CSR_HIGH_FREQ: sched_cfg.high_freq = val[11:0];
         CSR_LOW_FREQ:  sched_cfg.low_freq  = val[11:0];
         CSR_ACTIVE_PW: sched_cfg.active_pw = val;
         CSR_IDLE_PW:   sched_cfg.idle_pw   = val;
         default: ;
      endcase
   endtask

   initial begin
      sched_cfg = '{THRESHOLD_RST, HIGH_FREQ_RST, LOW_FREQ_RST, ACTIVE_PW_RST, IDLE_PW_RST};
      batch_count = 0; batch_total = 0; batch_dropped = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: lone task, zero total, ties, full batch with drop, extremes
      add_task(8'hFF, 16'hFFFF, 8'hFF, 1'b1);
      add_task(8'h01, 16'h0000, 8'h05, 1'b0);
      add_task(8'h02, 16'h0000, 8'h00, 1'b1);
      add_task(8'h10, 16'd10, 8'h07, 1'b0);
      add_task(8'h11, 16'd20, 8'h07, 1'b0);
      add_task(8'h12, 16'd30, 8'h03, 1'b1);
      for (int i = 0; i < 10; i++)
         add_task(8'(i), 16'(1000 * i), 8'(9 - i), i == 9);
      wait_drained();

      // register extremes: zero high frequency, low above high, wide power
      write_reg(CSR_THRESHOLD, 16'd0);
      write_reg(CSR_HIGH_FREQ, 16'd0);
      write_reg(CSR_LOW_FREQ, 16'd4095);
      write_reg(CSR_ACTIVE_PW, 16'hFFFF);
      write_reg(CSR_IDLE_PW, 16'hFFFF);
      write_reg(3'd7, 16'h1234);
      add_task(8'hAA, 16'd5, 8'h01, 1'b0);
      add_task(8'h55, 16'd5, 8'h00, 1'b1);
      wait_drained();
      write_reg(CSR_HIGH_FREQ, 16'd1);
      write_reg(CSR_THRESHOLD, 16'd100);
      add_batch(3);
      wait_drained();

      // random phases across several settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_THRESHOLD, 16'($urandom_range(100)));
         write_reg(CSR_HIGH_FREQ, 16'($urandom_range(4095, 1)));
         write_reg(CSR_LOW_FREQ, 16'($urandom_range(4095, 1)));
         write_reg(CSR_ACTIVE_PW, 16'($urandom));
         write_reg(CSR_IDLE_PW, 16'($urandom));
         quiet_phase = (ph == 1);
         for (int b = 0; b < 16; b++)
            add_batch(($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(7, 1));
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps offering words
            hold_rsp = 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         wait_drained();
      end
      write_reg(CSR_THRESHOLD, THRESHOLD_RST);
      write_reg(CSR_HIGH_FREQ, HIGH_FREQ_RST);
      write_reg(CSR_LOW_FREQ, LOW_FREQ_RST);
      add_batch(5);
      wait_drained();

      $display("ran %0d batches, %0d result words checked, %0d mismatches",
               batches_sent, words_seen, error_count);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

### sim.f
rtl/psds_pkg.sv
rtl/psds_front.sv
rtl/psds_queue.sv
rtl/psds_back.sv
rtl/priority_sort_dvfs_scheduler.sv
tb/tb_top.sv
